/* src/pauli_string_parser_defines.svh */
// assertion macros shared by the pauli string parser rtl
`ifndef PAULI_STRING_PARSER_DEFINES_SVH
`define PAULI_STRING_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/psp_pkg.sv */
// types and constants of the pauli string parser
`timescale 1ns / 1ps

package psp_pkg;

   localparam int NUM_QUBITS  = 16;
   localparam int TERM_SLOTS  = 16;
   localparam int QUBIT_LIMIT = (NUM_QUBITS < TERM_SLOTS) ? NUM_QUBITS : TERM_SLOTS;
   localparam int SLOT_W      = $clog2(TERM_SLOTS);
   localparam int TERM_W      = 2 * TERM_SLOTS;
   localparam int INDEX_W     = 16;
   localparam int PROD_W      = INDEX_W + 4;

   localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

   localparam logic [7:0] CHAR_X     = 8'h58;
   localparam logic [7:0] CHAR_Y     = 8'h59;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [3:0] DECIMAL    = 4'd10;

   typedef enum logic [1:0] {
      PAULI_I = 2'd0,
      PAULI_X = 2'd1,
      PAULI_Y = 2'd2,
      PAULI_Z = 2'd3
   } pauli_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_FACTOR = 2'd1,
      ERR_RANGE  = 2'd2
   } err_code_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [TERM_W-1:0] term_bits;
      logic [1:0]        phase_exp;
      err_code_type      error_code;
   } rsp_word_type;

endpackage

/* src/psp_fold.sv */
// single-qubit pauli product folded into one slot of the packed term
`timescale 1ns / 1ps

module psp_fold import psp_pkg::*; (
   input  logic [TERM_W-1:0] term_cur,
   input  logic [SLOT_W-1:0] slot,
   input  pauli_type         pauli,
   output logic [TERM_W-1:0] term_next,
   output logic [1:0]        phase_step
);

   logic [1:0] old_code;
   logic [1:0] new_code;
   logic [1:0] cyc_next;

   always_comb begin
      old_code = term_cur[{slot, 1'b0} +: 2];
      // cyclic successor x->y->z->x
      case (old_code)
         PAULI_X: cyc_next = PAULI_Y;
         PAULI_Y: cyc_next = PAULI_Z;
         PAULI_Z: cyc_next = PAULI_X;
         default: cyc_next = PAULI_X;
      endcase
      if (old_code == PAULI_I) begin
         new_code   = pauli;
         phase_step = 2'd0;
      end else if (old_code == pauli) begin
         new_code   = PAULI_I;
         phase_step = 2'd0;
      end else begin
         new_code   = old_code ^ pauli;
         phase_step = (pauli == cyc_next) ? 2'd1 : 2'd3;
      end
      term_next = term_cur;
      term_next[{slot, 1'b0} +: 2] = new_code;
   end

endmodule

/* src/pauli_string_parser.sv */
// pauli string parser top level. characters of a factor list such as "X0 Z2 Y3" arrive one
// word per cycle on req_, the final character flagged by is_last. each factor is X, Y or Z
// followed by a decimal qubit index; factors fold into a packed term of 2 bits per qubit
// (0 I, 1 X, 2 Y, 3 Z) and repeated qubits multiply through the pauli product table, the
// phase i^k being kept modulo 4. one rsp_ word follows every last character with the term,
// phase and error code (0 ok, 1 bad factor, 2 qubit index out of range); on error term and
// phase read zero and later characters up to the last are ignored. throughput is one
// character per cycle while no last character waits on a stalled result register: a
// character is captured into the input register; when it advances, the parser state is
// updated in place and, for a last character, the result register is loaded. the loop
// that sets the rate is the state update (decimal accumulate plus one pauli fold).
// stall on rsp_ only back-pressures req_ while a last character waits on a full result
// register.
`timescale 1ns / 1ps
`include "pauli_string_parser_defines.svh"

module pauli_string_parser import psp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // character words in
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   // result words out
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // input register
   logic         stage_valid_ff, stage_valid_in;
   req_word_type stage_ff, stage_in;

   // parser state
   logic [TERM_W-1:0]  term_ff, term_in;
   logic [1:0]         phase_ff, phase_in;
   pauli_type          letter_ff, letter_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               digit_ff, digit_in;
   err_code_type       err_ff, err_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   // handshake
   logic req_take;
   logic advance;
   logic out_load;

   // after the character itself
   logic               is_ws;
   pauli_type          letter1;
   logic [INDEX_W-1:0] index1;
   logic               digit1;
   err_code_type       err1;
   logic [PROD_W-1:0]  index_prod;

   // after closing an open factor
   logic               close_now;
   logic               fold_en;
   pauli_type          letter2;
   logic [INDEX_W-1:0] index2;
   logic               digit2;
   err_code_type       err2;
   logic [TERM_W-1:0]  term2;
   logic [1:0]         phase2;

   logic [TERM_W-1:0]  fold_term;
   logic [1:0]         fold_phase;

   // the stage moves on unless a last character meets a stalled full result register
   assign advance   = stage_valid_ff &&
                      (!stage_ff.is_last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign out_load  = advance && stage_ff.is_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   psp_fold u_fold (
      .term_cur   (term_ff),
      .slot       (index1[SLOT_W-1:0]),
      .pauli      (letter1),
      .term_next  (fold_term),
      .phase_step (fold_phase)
   );

   // character step: letter, digit or whitespace
   always_comb begin
      is_ws      = (stage_ff.char_in == CHAR_SPACE) ||
                   (stage_ff.char_in inside {[CHAR_TAB:CHAR_CR]});
      letter1    = letter_ff;
      index1     = index_ff;
      digit1     = digit_ff;
      err1       = err_ff;
      // index times ten plus digit, saturating
      index_prod = ({{(PROD_W-INDEX_W){1'b0}}, index_ff} << 3) +
                   ({{(PROD_W-INDEX_W){1'b0}}, index_ff} << 1) +
                   PROD_W'(stage_ff.char_in - CHAR_0);
      if (err_ff == ERR_NONE && !is_ws) begin
         if (letter_ff == PAULI_I) begin
            case (stage_ff.char_in)
               CHAR_X:  letter1 = PAULI_X;
               CHAR_Y:  letter1 = PAULI_Y;
               CHAR_Z:  letter1 = PAULI_Z;
               default: err1    = ERR_FACTOR;
            endcase
         end else if (stage_ff.char_in inside {[CHAR_0:CHAR_9]}) begin
            index1 = (index_prod > PROD_W'(INDEX_MAX)) ? INDEX_MAX
                                                       : index_prod[INDEX_W-1:0];
            digit1 = 1'b1;
         end else begin
            err1 = ERR_FACTOR;
         end
      end
   end

   // factor close: on whitespace, or at the end of the list
   always_comb begin
      close_now = (err_ff == ERR_NONE && is_ws) ||
                  (stage_ff.is_last && err1 == ERR_NONE);
      fold_en   = 1'b0;
      letter2   = letter1;
      index2    = index1;
      digit2    = digit1;
      err2      = err1;
      if (close_now && letter1 != PAULI_I) begin
         if (!digit1) begin
            err2 = ERR_FACTOR;
         end else if (index1 >= INDEX_W'(QUBIT_LIMIT)) begin
            err2 = ERR_RANGE;
         end else begin
            fold_en = 1'b1;
         end
         letter2 = PAULI_I;
         index2  = '0;
         digit2  = 1'b0;
      end
      term2  = fold_en ? fold_term : term_ff;
      phase2 = fold_en ? (phase_ff + fold_phase) : phase_ff;
   end

   // next values of registers
   always_comb begin
      stage_valid_in = req_take || (stage_valid_ff && !advance);
      stage_in       = req_take ? req_word : stage_ff;

      term_in   = term_ff;
      phase_in  = phase_ff;
      letter_in = letter_ff;
      index_in  = index_ff;
      digit_in  = digit_ff;
      err_in    = err_ff;
      if (advance) begin
         if (stage_ff.is_last) begin
            // list done, back to the identity
            term_in   = '0;
            phase_in  = '0;
            letter_in = PAULI_I;
            index_in  = '0;
            digit_in  = 1'b0;
            err_in    = ERR_NONE;
         end else begin
            term_in   = term2;
            phase_in  = phase2;
            letter_in = letter2;
            index_in  = index2;
            digit_in  = digit2;
            err_in    = err2;
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (out_load) begin
         rsp_in.error_code = err2;
         rsp_in.term_bits  = (err2 == ERR_NONE) ? term2 : '0;
         rsp_in.phase_exp  = (err2 == ERR_NONE) ? phase2 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         term_ff        <= '0;
         phase_ff       <= '0;
         letter_ff      <= PAULI_I;
         index_ff       <= '0;
         digit_ff       <= 1'b0;
         err_ff         <= ERR_NONE;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         term_ff        <= term_in;
         phase_ff       <= phase_in;
         letter_ff      <= letter_in;
         index_ff       <= index_in;
         digit_ff       <= digit_in;
         err_ff         <= err_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

   // checks
   `PSP_ASSERT_IMP(a_err_word_zero, clock, reset, rsp_valid_ff && rsp_ff.error_code != ERR_NONE, rsp_ff.term_bits == '0 && rsp_ff.phase_exp == 2'd0, "error word carries a term or phase")
   `PSP_ASSERT_NXT(a_state_cleared, clock, reset, out_load, letter_ff == PAULI_I && index_ff == '0 && digit_ff == 1'b0 && err_ff == ERR_NONE && term_ff == '0, "parser state not cleared after a result")
   `PSP_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, stage_valid_ff && stage_ff.is_last && rsp_valid_ff && rsp_stall, "input stalled without a blocked result")
   `PSP_ASSERT_NXT(a_err_sticky, clock, reset, err_ff != ERR_NONE && !out_load, err_ff == $past(err_ff), "first error not kept")

endmodule

/* tb/psp_term_checker.sv */
// checker for the pauli string parser: predicts each result word and compares it
`timescale 1ns / 1ps

module psp_term_checker import psp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           words_pending
);

   // predicted parser state
   logic [TERM_W-1:0] term_acc;
   logic [1:0]        phase_acc;
   pauli_type         open_letter;
   int unsigned       index_acc;
   logic              digit_seen;
   err_code_type      first_err;

   rsp_word_type      expected_terms[$];
   int                errors_seen = 0;

   assign fail_count = errors_seen;

   function automatic bit is_space(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // successor in the cycle x -> y -> z -> x gives +i
   function automatic pauli_type cyclic_next(pauli_type p);
      case (p)
         PAULI_X: return PAULI_Y;
         PAULI_Y: return PAULI_Z;
         default: return PAULI_X;
      endcase
   endfunction

   task automatic clear_parser();
      term_acc    = '0;
      phase_acc   = '0;
      open_letter = PAULI_I;
      index_acc   = 0;
      digit_seen  = 1'b0;
      first_err   = ERR_NONE;
   endtask

   task automatic flag_error(err_code_type code);
      if (first_err == ERR_NONE) first_err = code;
   endtask

   task automatic merge_pauli(int unsigned qubit, pauli_type p);
      int        sh;
      pauli_type prev;
      sh   = qubit * 2;
      prev = pauli_type'(term_acc[sh +: 2]);
      if (prev == PAULI_I) begin
         term_acc[sh +: 2] = p;
      end else if (prev == p) begin
         term_acc[sh +: 2] = PAULI_I;
      end else begin
         term_acc[sh +: 2] = prev ^ p;
         phase_acc = phase_acc + ((p == cyclic_next(prev)) ? 2'd1 : 2'd3);
      end
   endtask

   task automatic close_factor();
      if (open_letter == PAULI_I) return;
      if (!digit_seen) flag_error(ERR_FACTOR);
      else if (index_acc >= QUBIT_LIMIT) flag_error(ERR_RANGE);
      else merge_pauli(index_acc, open_letter);
      open_letter = PAULI_I;
      index_acc   = 0;
      digit_seen  = 1'b0;
   endtask

   task automatic parse_char(logic [7:0] c, logic last);
      rsp_word_type want;
      if (first_err == ERR_NONE) begin
         if (is_space(c)) begin
            close_factor();
         end else if (open_letter == PAULI_I) begin
            if (c == CHAR_X) open_letter = PAULI_X;
            else if (c == CHAR_Y) open_letter = PAULI_Y;
            else if (c == CHAR_Z) open_letter = PAULI_Z;
            else flag_error(ERR_FACTOR);
         end else if (c < CHAR_0 || c > CHAR_9) begin
            flag_error(ERR_FACTOR);
         end else begin
            index_acc  = index_acc * DECIMAL + (c - CHAR_0);
            if (index_acc > INDEX_MAX) index_acc = INDEX_MAX;
            digit_seen = 1'b1;
         end
      end
      if (last) begin
         if (first_err == ERR_NONE) close_factor();
         want.term_bits  = (first_err == ERR_NONE) ? term_acc : '0;
         want.phase_exp  = (first_err == ERR_NONE) ? phase_acc : '0;
         want.error_code = first_err;
         expected_terms  = {expected_terms, want};
         clear_parser();
      end
   endtask

   task automatic check_result(rsp_word_type got);
      rsp_word_type want;
      if (expected_terms.size() == 0) begin
         $error("result word with no character list pending");
         errors_seen++;
      end else begin
         want = expected_terms.pop_front();
         if (got.term_bits !== want.term_bits) begin
            $error("term_bits: expected %h, got %h", want.term_bits, got.term_bits);
            errors_seen++;
         end
         if (got.phase_exp !== want.phase_exp) begin
            $error("phase_exp: expected %0d, got %0d", want.phase_exp, got.phase_exp);
            errors_seen++;
         end
         if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            errors_seen++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_terms.delete();
         words_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_word);
         if (req_valid && !req_stall) parse_char(req_word.char_in, req_word.is_last);
         words_pending <= expected_terms.size();
      end
   end

endmodule

/* tb/tb.sv */
// top of the pauli string parser testbench: stimulus, idling and the verdict
`timescale 1ns / 1ps

module tb;
   import psp_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   int           fail_count;
   int           words_pending;

   // chances in a hundred that the sender idles or the receiver stalls
   int unsigned  send_idle_pct;
   int unsigned  stall_pct;

   // characters of the factor list being built
   logic [7:0]   line_chars[$];

   pauli_string_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   psp_term_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous ceiling, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // one character word; valid is only lowered when the sender chooses to idle, so it
   // never gets two assignments in one step, and the word holds until it is taken
   task automatic send_char(logic [7:0] c, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= '{char_in: c, is_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sends the queued characters, the final one flagged as last
   task automatic send_line();
      for (int i = 0; i < line_chars.size(); i++) begin
         send_char(line_chars[i], i == line_chars.size() - 1);
      end
   endtask

   task automatic send_text(string s);
      line_chars.delete();
      for (int i = 0; i < s.len(); i++) line_chars = {line_chars, s[i]};
      send_line();
   endtask

   // sender holds off until every predicted result has been seen, then idles a while longer
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_space();
      int unsigned w;
      w = $urandom_range(5);
      return (w == 5) ? CHAR_SPACE : CHAR_TAB + w[7:0];
   endfunction

   // mostly well-formed factor lists with random content, the rest broken or pure noise
   task automatic build_random_line();
      int unsigned kind;
      int unsigned n_factors;
      int unsigned idx;
      int unsigned pick;
      string       digits;
      kind = $urandom_range(99);
      line_chars.delete();
      if (kind >= 90) begin
         // noise: arbitrary bytes
         repeat ($urandom_range(1, 6)) line_chars = {line_chars, 8'($urandom_range(255))};
      end else begin
         n_factors = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(4) == 0) line_chars = {line_chars, pick_space()};
         for (int f = 0; f < n_factors; f++) begin
            if (f > 0) begin
               line_chars = {line_chars, pick_space()};
               if ($urandom_range(3) == 0) line_chars = {line_chars, pick_space()};
            end
            pick = $urandom_range(2);
            line_chars = {line_chars,
                          (pick == 0) ? CHAR_X : ((pick == 1) ? CHAR_Y : CHAR_Z)};
            // low qubits are favoured so that repeats, and so the product table, come up often
            pick = $urandom_range(99);
            if (pick < 50) idx = $urandom_range(3);
            else if (pick < 90) idx = $urandom_range(QUBIT_LIMIT - 1);
            else if (pick < 96) idx = $urandom_range(QUBIT_LIMIT, 99);
            else idx = $urandom_range(999999);
            if ($urandom_range(9) == 0) line_chars = {line_chars, CHAR_0};
            digits = $sformatf("%0d", idx);
            for (int j = 0; j < digits.len(); j++) line_chars = {line_chars, digits[j]};
         end
         if (line_chars.size() == 0 || $urandom_range(3) == 0) begin
            line_chars = {line_chars, pick_space()};
         end
         // broken list: one character overwritten by a random byte
         if (kind >= 75) begin
            line_chars[$urandom_range(line_chars.size() - 1)] = 8'($urandom_range(255));
         end
      end
   endtask

   initial begin
      int sent;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      send_idle_pct = 6;
      stall_pct     = 76;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lists
      send_text(" ");             // empty list gives the identity
      send_text("X0 Y0");         // xy = iz
      send_text("Z1\tY1");        // zy = -ix, tab as separator
      send_char(8'hFF, 1'b0);     // bad letter, later factor ignored
      send_text(" X1");
      send_text("Y");             // letter with no digits at the end
      send_text("X7Q");           // non-digit after a digit
      send_text("X16");           // first index past the qubit limit
      send_text("Y70000");        // index saturates, so out of range
      send_text("Z15 X0 ");       // top slot, trailing whitespace
      drain_results();

      // three idling regimes, each followed by a full drain
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : ((phase == 1) ? 76 : 0);
         stall_pct     = (phase == 0) ? 76 : ((phase == 1) ? 6 : 0);
         sent = 0;
         while (sent < 275) begin
            build_random_line();
            sent += line_chars.size();
            send_line();
         end
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
